FILE: rtl/tpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpd_pkg: shared types and constants of the TGA pixel stream decoder
// Configuration layout, result status codes and the event record that travels
// from the packet parser to the pixel formatter.
// ----------------------------------------------------------------------------
package tpd_pkg;

  localparam int CFG_W        = 25;  // widest configuration register
  localparam int CFG_IDX_W    = 2;
  localparam int PIX_W        = 32;  // up to four bytes of one pixel
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [2:0] BPP_RGB     = 3'd3;   // three bytes a pixel, no alpha
  localparam logic [2:0] PIX_SIZE_3  = 3'd3;
  localparam logic [2:0] PIX_SIZE_4  = 3'd4;
  localparam logic [7:0] RUN_BIAS    = 8'd127; // run header minus this is the run length

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BPP         = 2'd0,
    CFG_PIXEL_COUNT = 2'd1,
    CFG_COMPRESSED  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_EARLY_END = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]       bytes_per_pixel;
    logic [CFG_W-1:0] pixel_count;
    logic             compressed;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_bytes;  // B in [7:0], G, R, A in [31:24]
    logic             four;         // pixel carries alpha
    logic [7:0]       count;
    logic             last;
    status_t          status;
  } event_t;

endpackage
`default_nettype wire

FILE: rtl/tpd_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpd_ifs: stream channels of the TGA pixel stream decoder
// Byte input channel and decoded pixel result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, data_byte, stream_end, input ready);
  modport sink   (input valid, data_byte, stream_end, output ready);
endinterface

interface tpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [7:0] repeat_res;
  logic       last;
  logic [1:0] status;

  modport source (output valid, red, green, blue, alpha, repeat_res, last, status,
                  input ready);
  modport sink   (input valid, red, green, blue, alpha, repeat_res, last, status,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/tpd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpd_front: packet parser
// Takes one payload byte a cycle unless the queue is full, tracks packet
// headers, assembles pixels, queues an event per finished pixel, run or error.
// ----------------------------------------------------------------------------
module tpd_front #(
  parameter int PIXEL_COUNT_BITS = 24
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tpd_pkg::cfg_t   cfg,
  tpd_in_if.sink          in_chan,
  input  logic            q_full,
  output logic            push,
  output tpd_pkg::event_t ev
);
  import tpd_pkg::*;

  localparam int CW = PIXEL_COUNT_BITS + 1;
  localparam int MW = (CW > CFG_W) ? CW : CFG_W;
  localparam int SW = CW + 1;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_PIXEL  = 4'b0010,
    PH_DONE   = 4'b0100,
    PH_ERROR  = 4'b1000
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [1:0]       byte_idx_r, byte_idx_nxt;
  logic [PIX_W-1:0] pix_r, pix_nxt;
  logic [7:0]       left_r, left_nxt;
  logic [CW-1:0]    done_r, done_nxt;
  logic             run_r, run_nxt;

  logic [MW-1:0]    cap, pc_ext, lim_wide;
  logic [CW-1:0]    limit;
  logic             accept, live, is_hdr, hdr_pkt, done_ge;
  logic [7:0]       b;
  logic [2:0]       size;
  logic [1:0]       eff_idx;
  logic [PIX_W-1:0] eff_pix, pix_new;
  logic [7:0]       eff_left, add_cnt;
  logic             eff_run, complete;
  logic [SW-1:0]    sum;
  logic             over, full_after;

  // Saturate the image size to what the pixel counter can reach.
  assign cap      = MW'(1) << PIXEL_COUNT_BITS;
  assign pc_ext   = MW'(cfg.pixel_count);
  assign lim_wide = (pc_ext > cap) ? cap : pc_ext;
  assign limit    = lim_wide[CW-1:0];

  assign in_chan.ready = !q_full;
  assign accept  = in_chan.valid && in_chan.ready;
  assign b       = in_chan.data_byte;
  assign live    = (phase_r == PH_HEADER) || (phase_r == PH_PIXEL);
  assign is_hdr  = (phase_r == PH_HEADER);
  assign hdr_pkt = is_hdr && cfg.compressed;
  assign done_ge = done_r >= limit;
  assign size    = (cfg.bytes_per_pixel == BPP_RGB) ? PIX_SIZE_3 : PIX_SIZE_4;

  // An uncompressed header slot is a one-pixel raw packet starting here.
  assign eff_idx  = is_hdr ? 2'd0 : byte_idx_r;
  assign eff_pix  = is_hdr ? '0 : pix_r;
  assign eff_left = is_hdr ? 8'd1 : left_r;
  assign eff_run  = is_hdr ? 1'b0 : run_r;

  assign pix_new  = eff_pix | (PIX_W'(b) << {eff_idx, 3'b000});
  assign complete = ({1'b0, eff_idx} + 3'd1) >= size;

  // One adder serves the raw packet check, the run check and the pixel count.
  assign add_cnt    = hdr_pkt ? (b + 8'd1) : (eff_run ? eff_left : 8'd1);
  assign sum        = SW'(done_r) + SW'(add_cnt);
  assign over       = sum >  {1'b0, limit};
  assign full_after = sum >= {1'b0, limit};

  always_comb begin
    phase_nxt    = phase_r;
    byte_idx_nxt = byte_idx_r;
    pix_nxt      = pix_r;
    left_nxt     = left_r;
    done_nxt     = done_r;
    run_nxt      = run_r;
    push         = 1'b0;
    ev           = '0;
    ev.status    = ST_OK;
    if (accept && live) begin
      priority if (done_ge) begin
        phase_nxt = PH_DONE;
      end else if (in_chan.stream_end) begin
        push      = 1'b1;
        ev.status = ST_EARLY_END;
        phase_nxt = PH_ERROR;
      end else if (hdr_pkt) begin
        byte_idx_nxt = 2'd0;
        pix_nxt      = '0;
        if (!b[7]) begin
          if (over) begin
            push      = 1'b1;
            ev.status = ST_OVERFLOW;
            phase_nxt = PH_ERROR;
          end else begin
            left_nxt  = b + 8'd1;
            run_nxt   = 1'b0;
            phase_nxt = PH_PIXEL;
          end
        end else begin
          left_nxt  = b - RUN_BIAS;
          run_nxt   = 1'b1;
          phase_nxt = PH_PIXEL;
        end
      end else if (!complete) begin
        byte_idx_nxt = eff_idx + 2'd1;
        pix_nxt      = pix_new;
        left_nxt     = eff_left;
        run_nxt      = eff_run;
        phase_nxt    = PH_PIXEL;
      end else if (eff_run && over) begin
        push      = 1'b1;
        ev.status = ST_OVERFLOW;
        phase_nxt = PH_ERROR;
      end else begin
        left_nxt       = eff_run ? 8'd0 : ((eff_left != 8'd0) ? eff_left - 8'd1 : 8'd0);
        run_nxt        = eff_run;
        done_nxt       = sum[CW-1:0];
        byte_idx_nxt   = 2'd0;
        pix_nxt        = '0;
        push           = 1'b1;
        ev.pixel_bytes = pix_new;
        ev.four        = (size == PIX_SIZE_4);
        ev.count       = add_cnt;
        ev.last        = full_after;
        if (full_after) begin
          phase_nxt = PH_DONE;
        end else if (left_nxt == 8'd0) begin
          phase_nxt = PH_HEADER;
        end else begin
          phase_nxt = PH_PIXEL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      byte_idx_r <= 2'd0;
      pix_r      <= '0;
      left_r     <= 8'd0;
      done_r     <= '0;
      run_r      <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      byte_idx_r <= byte_idx_nxt;
      pix_r      <= pix_nxt;
      left_r     <= left_nxt;
      done_r     <= done_nxt;
      run_r      <= run_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full) else $error("event pushed into a full queue");
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (push && ev.last) |=> (phase_r == PH_DONE)) else $error("image end not latched");
  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ERROR) |-> !push) else $error("event after error");
`endif

endmodule
`default_nettype wire

FILE: rtl/tpd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpd_queue: event queue
// Short FIFO between parser and formatter so each side stalls on its own.
// ----------------------------------------------------------------------------
module tpd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tpd_pkg::event_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            rvalid,
  output tpd_pkg::event_t rdata
);
  import tpd_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  event_t        mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] cnt_r, cnt_nxt;

  assign full   = (cnt_r == NW'(QUEUE_DEPTH));
  assign rvalid = (cnt_r != '0);
  assign rdata  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + NW'(1);
      2'b01:   cnt_nxt = cnt_r - NW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NW'(QUEUE_DEPTH)) else $error("queue fill out of range");
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> rvalid) else $error("pop from empty queue");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ptr_r == PW'(rd_ptr_r + cnt_r)) else $error("queue pointers out of step");
`endif

endmodule
`default_nettype wire

FILE: rtl/tpd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpd_back: pixel formatter
// Reorders BGR(A) into RGB(A), blanks error results and holds the output
// register of the result channel.
// ----------------------------------------------------------------------------
module tpd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  tpd_pkg::event_t q_data,
  output logic            pop,
  tpd_out_if.source       out_chan
);
  import tpd_pkg::*;

  logic       out_valid_r;
  logic [7:0] red_r, green_r, blue_r, alpha_r, repeat_r;
  logic       last_r;
  status_t    status_r;
  logic       take, ok;

  assign take = !out_valid_r || out_chan.ready;
  assign pop  = q_valid && take;
  assign ok   = (q_data.status == ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      red_r    <= ok ? q_data.pixel_bytes[23:16] : 8'd0;
      green_r  <= ok ? q_data.pixel_bytes[15:8]  : 8'd0;
      blue_r   <= ok ? q_data.pixel_bytes[7:0]   : 8'd0;
      alpha_r  <= (ok && q_data.four) ? q_data.pixel_bytes[31:24] : 8'd0;
      repeat_r <= ok ? q_data.count : 8'd0;
      last_r   <= ok && q_data.last;
      status_r <= q_data.status;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.red        = red_r;
  assign out_chan.green      = green_r;
  assign out_chan.blue       = blue_r;
  assign out_chan.alpha      = alpha_r;
  assign out_chan.repeat_res = repeat_r;
  assign out_chan.last       = last_r;
  assign out_chan.status     = status_r;

`ifndef NO_ASSERTIONS
  a_err_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ST_OK) |-> (repeat_r == 8'd0 && !last_r))
    else $error("error result carries pixel data");
  a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_OK) |-> (repeat_r != 8'd0))
    else $error("pixel result with zero repeat");
  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid_r) else $error("popped event not presented");
`endif

endmodule
`default_nettype wire

FILE: rtl/tga_pixel_stream_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder_unit: TGA run-length pixel stream decoder
// Decodes the pixel payload of a TGA image, byte by byte, into RGB(A) pixels
// and runs with a repeat count, flagging overflowing packets and early ends.
// ----------------------------------------------------------------------------
// Path: a byte that completes a pixel, run or error is written into the event
//   queue at its own transfer edge; the oldest queued event loads the output
//   register when that is empty or read, and is then presented on out_chan.
// Throughput: one byte a cycle while the event queue has room, as set by the
//   packet parser; up to one result a cycle leaves the output register.
// Reset: synchronous, active low; clears the parser, queue and output valid,
//   and loads the registers with 4 bytes per pixel, 1 pixel, compressed mode.
// ----------------------------------------------------------------------------
module tga_pixel_stream_decoder_unit #(
  parameter int PIXEL_COUNT_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpd_pkg::CFG_W-1:0]     cfg_wdata,
  tpd_in_if.sink                        in_chan,
  tpd_out_if.source                     out_chan
);
  import tpd_pkg::*;

  cfg_t   cfg_r;
  logic   push, q_full, pop, q_valid;
  event_t push_ev, q_data;

  // Configuration registers; the user is to write them only while the decoder is
  // idle (unchecked by the block), so the parser reads them directly.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bytes_per_pixel <= 3'd4;
      cfg_r.pixel_count     <= CFG_W'(1);
      cfg_r.compressed      <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BPP:         cfg_r.bytes_per_pixel <= cfg_wdata[2:0];
        CFG_PIXEL_COUNT: cfg_r.pixel_count     <= cfg_wdata;
        CFG_COMPRESSED:  cfg_r.compressed      <= cfg_wdata[0];
        default:         cfg_r                 <= cfg_r;  // unmapped index: drop
      endcase
    end
  end

  // Front: classify each byte as packet header, pixel byte or stream end.
  tpd_front #(
    .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_chan (in_chan),
    .q_full  (q_full),
    .push    (push),
    .ev      (push_ev)
  );

  // Queue: absorb output stalls so the parser keeps taking bytes.
  tpd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wdata  (push_ev),
    .full   (q_full),
    .pop    (pop),
    .rvalid (q_valid),
    .rdata  (q_data)
  );

  // Back: format pixels and hold the result for transfer.
  tpd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire

FILE: dv/tga_pixel_stream_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder_unit_test: self-checking bench of the TGA decoder
// Streams payload bytes into the decoder under random stalls on both channels,
// predicts every pixel, run and error from a local decoder model, and checks
// each result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tga_pixel_stream_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tpd_pkg::*;

  localparam int          PIXEL_CAP_BITS = 24;
  localparam logic [31:0] PIXEL_CAP      = 32'd1 << PIXEL_CAP_BITS;
  localparam int          IDLE_PCT       = 7;      // idle chance per cycle, percent
  localparam int          HOLD_CYCLES    = 300;    // long receiver hold-off
  localparam int          SETTLE_CYCLES  = 4;      // covers the event queue and output register
  localparam int          RANDOM_BYTES   = 1150;
  localparam int          CYCLE_LIMIT    = 200000;

  // Decoder phase of the local model
  typedef enum logic [1:0] {
    DEC_HEADER,
    DEC_PIXEL,
    DEC_DONE,
    DEC_ERROR
  } dec_phase_t;

  // How the single image of the run is brought to its end
  typedef enum logic [1:0] {
    END_FILL,
    END_OVERFLOW,
    END_EARLY,
    END_LOWER
  } image_end_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] count;
    logic       last;
    status_t    status;
  } pixel_res_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  tpd_in_if  in_ch ();
  tpd_out_if out_ch ();

  tga_pixel_stream_decoder_unit #(
    .PIXEL_COUNT_BITS(PIXEL_CAP_BITS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the configuration registers
  logic [2:0]  cfg_bpp;
  logic [24:0] cfg_pixels;
  logic        cfg_rle;

  // Local decoder state
  dec_phase_t  dec_phase;
  logic [1:0]  dec_index;
  logic [31:0] dec_bytes;
  logic [7:0]  dec_left;
  logic [31:0] dec_done;
  logic        dec_run;

  pixel_res_t expected_pixels[$];

  int errors       = 0;
  int cycles       = 0;
  bit quiet        = 1'b0;  // suppress idling on both channels
  int hold_trigger = 0;     // bump to start a long receiver hold-off

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------
  function automatic logic [31:0] image_limit();
    return ({7'd0, cfg_pixels} > PIXEL_CAP) ? PIXEL_CAP : {7'd0, cfg_pixels};
  endfunction

  function automatic logic [3:0] pixel_size();
    return (cfg_bpp == BPP_RGB) ? 4'd3 : 4'd4;
  endfunction

  // Queue an error result and stop the decoder
  function automatic void post_error(input status_t code);
    pixel_res_t r;
    r        = '0;
    r.status = code;
    dec_phase = DEC_ERROR;
    expected_pixels.push_back(r);
  endfunction

  // Advance the model by one accepted byte; queue the result it causes
  function automatic void decode_byte(input logic [7:0] b, input logic e);
    logic [31:0] lim;
    logic [3:0]  pix_size;
    logic [7:0]  cnt;
    pixel_res_t  r;
    lim      = image_limit();
    pix_size = pixel_size();
    if (dec_phase == DEC_ERROR || dec_phase == DEC_DONE) return;
    // Image already full: everything is ignored from here on
    if (dec_done >= lim) begin
      dec_phase = DEC_DONE;
      return;
    end
    if (e) begin
      post_error(ST_EARLY_END);
      return;
    end
    if (dec_phase == DEC_HEADER) begin
      dec_index = 2'd0;
      dec_bytes = '0;
      if (!cfg_rle) begin
        // Plain pixel: this byte is already the first pixel byte
        dec_left  = 8'd1;
        dec_run   = 1'b0;
        dec_phase = DEC_PIXEL;
      end else if (b < 8'd128) begin
        // Raw packet: check the whole packet against the image size now
        if (dec_done + b + 1 > lim) begin
          post_error(ST_OVERFLOW);
          return;
        end
        dec_left  = b + 8'd1;
        dec_run   = 1'b0;
        dec_phase = DEC_PIXEL;
        return;
      end else begin
        dec_left  = b - RUN_BIAS;
        dec_run   = 1'b1;
        dec_phase = DEC_PIXEL;
        return;
      end
    end
    // Collect one pixel byte; size is taken as it stands now
    dec_bytes = dec_bytes | ({24'd0, b} << (dec_index * 8));
    if (dec_index + 1 < pix_size) begin
      dec_index = dec_index + 2'd1;
      return;
    end
    if (dec_run) begin
      // Run packet: checked once its color is complete
      cnt = dec_left;
      if (dec_done + cnt > lim) begin
        post_error(ST_OVERFLOW);
        return;
      end
      dec_left = 8'd0;
    end else begin
      cnt = 8'd1;
      if (dec_left != 8'd0) dec_left = dec_left - 8'd1;
    end
    dec_done = dec_done + cnt;
    r.red    = dec_bytes[23:16];
    r.green  = dec_bytes[15:8];
    r.blue   = dec_bytes[7:0];
    r.alpha  = (pix_size == 4'd4) ? dec_bytes[31:24] : 8'd0;
    r.count  = cnt;
    r.last   = (dec_done >= lim);
    r.status = ST_OK;
    dec_index = 2'd0;
    dec_bytes = '0;
    if (r.last) dec_phase = DEC_DONE;
    else if (dec_left == 8'd0) dec_phase = DEC_HEADER;
    expected_pixels.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [7:0] pixel_value();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Pick a byte that keeps the stream well formed: a header where one is due
  function automatic logic [7:0] next_byte();
    int pick;
    if (dec_phase == DEC_HEADER && cfg_rle) begin
      pick = $urandom_range(0, 39);
      if (pick < 16) return 8'($urandom_range(0, 3));        // short raw packet
      if (pick == 16) return 8'($urandom_range(0, 127));     // raw packet, any size
      if (pick < 37) return 8'($urandom_range(128, 255));    // run packet
      case ($urandom_range(0, 3))
        0:       return 8'd0;
        1:       return 8'd127;
        2:       return 8'd128;
        default: return 8'd255;
      endcase
    end
    return pixel_value();
  endfunction

  // Offer one byte, idling at random first; return once it is transferred
  task automatic send_byte(input logic [7:0] b, input logic e);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.stream_end <= e;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(b, e);
  endtask

  // Drop valid, drain all expected results, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write one register; only call while the decoder is idle
  task automatic write_reg(input cfg_idx_t idx, input logic [24:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_BPP:         cfg_bpp    = val[2:0];
      CFG_PIXEL_COUNT: cfg_pixels = val;
      CFG_COMPRESSED:  cfg_rle    = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Finish whatever pixel or packet is in progress
  task automatic finish_packet();
    while (dec_phase == DEC_PIXEL) send_byte(pixel_value(), 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_basic_packets();
    settle();
    write_reg(CFG_BPP, 25'd7);               // any size but three means four bytes
    write_reg(CFG_PIXEL_COUNT, 25'h1FFFFFF); // saturates to the pixel cap
    write_reg(CFG_COMPRESSED, 25'd1);
    // Raw packet of one pixel, all zero
    send_byte(8'd0, 1'b0);
    repeat (4) send_byte(8'h00, 1'b0);
    // Longest run, all ones
    send_byte(8'd255, 1'b0);
    repeat (4) send_byte(8'hFF, 1'b0);
    // Plain four-byte pixel with bytes per pixel at zero
    settle();
    write_reg(CFG_BPP, 25'd0);
    write_reg(CFG_COMPRESSED, 25'd0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h10, 1'b0);
  endtask

  task automatic test_mode_switch();
    settle();
    write_reg(CFG_BPP, 25'(BPP_RGB));
    write_reg(CFG_COMPRESSED, 25'd1);
    // Raw packet of two pixels; mode changes after the first one
    send_byte(8'd1, 1'b0);
    repeat (3) send_byte(pixel_value(), 1'b0);
    settle();
    write_reg(CFG_COMPRESSED, 25'd0);
    // Second pixel still belongs to the packet, the third is a plain pixel
    repeat (6) send_byte(pixel_value(), 1'b0);
  endtask

  task automatic test_size_switch();
    settle();
    write_reg(CFG_BPP, 25'(PIX_SIZE_4));
    write_reg(CFG_COMPRESSED, 25'd1);
    // Run of one: shrink to three bytes after the fourth byte is due
    send_byte(8'd128, 1'b0);
    repeat (3) send_byte(pixel_value(), 1'b0);
    settle();
    write_reg(CFG_BPP, 25'(BPP_RGB));
    send_byte(8'hC3, 1'b0);
    // Raw pixel: grow to four bytes after two bytes
    send_byte(8'd0, 1'b0);
    repeat (2) send_byte(pixel_value(), 1'b0);
    settle();
    write_reg(CFG_BPP, 25'(PIX_SIZE_4));
    repeat (2) send_byte(pixel_value(), 1'b0);
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    repeat (200) send_byte(next_byte(), 1'b0);
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    settle();
    write_reg(CFG_BPP, 25'(BPP_RGB));
    write_reg(CFG_COMPRESSED, 25'd0);
    // Hold the receiver off while plain pixels keep coming; the input must stall
    hold_trigger = hold_trigger + 1;
    repeat (120) send_byte(pixel_value(), 1'b0);
  endtask

  task automatic test_random_stream();
    repeat (RANDOM_BYTES) begin
      case ($urandom_range(0, 99))
        0: begin
          // Reconfigure at whatever point of a packet or pixel we are
          settle();
          case ($urandom_range(0, 2))
            0: write_reg(CFG_BPP, 25'($urandom_range(0, 7)));
            1: case ($urandom_range(0, 4))
                 0:       write_reg(CFG_PIXEL_COUNT, 25'h1FFFFFF);
                 1:       write_reg(CFG_PIXEL_COUNT, 25'h1000000);
                 2:       write_reg(CFG_PIXEL_COUNT, 25'h1000001);
                 3:       write_reg(CFG_PIXEL_COUNT, 25'h0FFFFFF);
                 default: write_reg(CFG_PIXEL_COUNT,
                                    25'($urandom_range(32'h100000, 32'h1FFFFFF)));
               endcase
            default: write_reg(CFG_COMPRESSED, 25'($urandom_range(0, 1)));
          endcase
        end
        1, 2, 3, 4, 5, 6, 7, 8, 9, 10: send_byte(8'($urandom_range(0, 255)), 1'b0);
        default: send_byte(next_byte(), 1'b0);
      endcase
    end
  endtask

  // The decoder never leaves its done or error state, so the run ends one way
  task automatic test_image_end();
    image_end_t  how;
    logic [31:0] rem;
    logic [31:0] n;
    how = image_end_t'($urandom_range(0, 3));
    case (how)
      END_FILL: begin
        // Shrink the image to a little more than is done, then fill it exactly
        finish_packet();
        settle();
        write_reg(CFG_PIXEL_COUNT, 25'(dec_done + $urandom_range(1, 300)));
        while (dec_phase != DEC_DONE) begin
          if (dec_phase == DEC_HEADER && cfg_rle) begin
            rem = image_limit() - dec_done;
            n   = $urandom_range(1, (rem < 128) ? rem : 128);
            if ($urandom_range(0, 1) != 0) send_byte(8'(n + 127), 1'b0);
            else send_byte(8'(n - 1), 1'b0);
          end else begin
            send_byte(pixel_value(), 1'b0);
          end
        end
      end
      END_OVERFLOW: begin
        finish_packet();
        settle();
        rem = $urandom_range(1, 127);
        write_reg(CFG_COMPRESSED, 25'd1);
        write_reg(CFG_PIXEL_COUNT, 25'(dec_done + rem));
        if ($urandom_range(0, 1) != 0) begin
          // Raw packet too large: flagged at its header
          send_byte(8'($urandom_range(rem, 127)), 1'b0);
        end else begin
          // Run too long: flagged once its color is complete
          send_byte(8'($urandom_range(rem + 1, 128) + 127), 1'b0);
          finish_packet();
        end
      end
      END_EARLY: begin
        repeat ($urandom_range(0, 5)) send_byte(next_byte(), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      default: begin
        // Lower the image to at most what is already done; zero half the time
        settle();
        if ($urandom_range(0, 1) != 0) write_reg(CFG_PIXEL_COUNT, 25'd0);
        else write_reg(CFG_PIXEL_COUNT, 25'($urandom_range(0, dec_done)));
      end
    endcase
    // Everything after the end is dropped, stream ends included
    repeat (40) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random idling, long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen    = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_trigger != hold_seen) begin
        hold_seen = hold_trigger;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (quiet) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      errors = errors + 1;
    end
  endfunction

  always @(posedge clk) begin : result_check
    pixel_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d n=%0d %0b %0d",
                 $realtime, out_ch.red, out_ch.green, out_ch.blue, out_ch.alpha,
                 out_ch.repeat_res, out_ch.last, out_ch.status);
        errors = errors + 1;
      end else begin
        want = expected_pixels.pop_front();
        check_field("red", want.red, out_ch.red);
        check_field("green", want.green, out_ch.green);
        check_field("blue", want.blue, out_ch.blue);
        check_field("alpha", want.alpha, out_ch.alpha);
        check_field("repeat_res", want.count, out_ch.repeat_res);
        check_field("last", {7'd0, want.last}, {7'd0, out_ch.last});
        check_field("status", {6'd0, want.status}, {6'd0, out_ch.status});
      end
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    // Drive every input to a known value from time zero
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_BPP;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'd0;
    in_ch.stream_end = 1'b0;
    // Model and shadow registers at their reset values
    cfg_bpp    = 3'd4;
    cfg_pixels = 25'd1;
    cfg_rle    = 1'b1;
    dec_phase  = DEC_HEADER;
    dec_index  = 2'd0;
    dec_bytes  = '0;
    dec_left   = 8'd0;
    dec_done   = '0;
    dec_run    = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_packets();
    test_mode_switch();
    test_size_switch();
    test_back_to_back();
    test_backpressure();
    test_random_stream();
    test_image_end();

    // Drain, then give stray results a chance to show
    settle();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tpd_pkg.sv
rtl/tpd_ifs.sv
rtl/tpd_front.sv
rtl/tpd_queue.sv
rtl/tpd_back.sv
rtl/tga_pixel_stream_decoder_unit.sv
dv/tga_pixel_stream_decoder_unit_test.sv
